// ===== rtl/pfrc_pkg.sv =====
// Shared types, constants and helpers for the pixel format to RGBA converter.
// No dependencies; used by every other file of the block.
`default_nettype none

package pfrc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FMT_W = 3;
  localparam int unsigned SUM_W = 20;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // pixel_format register codes
  localparam logic [FMT_W-1:0] FMT_RGB24 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_BGR24 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_GRAY8 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_NV12 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_NV21 = 3'd4;
  localparam logic [FMT_W-1:0] FMT_I420 = 3'd5;

  // register index, taken from paddr word bit
  localparam logic REG_PIXEL_FORMAT = 1'b0;

  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // BT.601 limited-range coefficients
  localparam logic signed [SUM_W-1:0] K_Y = 20'sd298;
  localparam logic signed [SUM_W-1:0] K_RV = 20'sd409;
  localparam logic signed [SUM_W-1:0] K_GU = 20'sd100;
  localparam logic signed [SUM_W-1:0] K_GV = 20'sd208;
  localparam logic signed [SUM_W-1:0] K_BU = 20'sd516;
  localparam logic signed [SUM_W-1:0] ROUND = 20'sd128;
  localparam logic signed [9:0] LUMA_OFS = 10'sd16;
  localparam logic signed [9:0] CHROMA_OFS = 10'sd128;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_t;

  // floor divide by 256 then saturate to 0..255
  function automatic logic [BYTE_W-1:0] clamp_shift(input logic signed [SUM_W-1:0] sum);
    logic [BYTE_W-1:0] res;
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (|sum[SUM_W-2:16]) begin
      res = 8'hFF;
    end else begin
      res = sum[15:8];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pfrc_if.sv =====
// Valid/ready stream interfaces for source pixels and RGBA results.
// Depends on pfrc_pkg for the byte width.
`default_nettype none

interface pfrc_pixel_if;
  logic                           valid;
  logic                           ready;
  logic [pfrc_pkg::BYTE_W-1:0]    first_byte;
  logic [pfrc_pkg::BYTE_W-1:0]    second_byte;
  logic [pfrc_pkg::BYTE_W-1:0]    third_byte;

  modport source (output valid, first_byte, second_byte, third_byte, input ready);
  modport sink (input valid, first_byte, second_byte, third_byte, output ready);
endinterface

interface pfrc_rgba_if;
  logic                           valid;
  logic                           ready;
  logic [pfrc_pkg::BYTE_W-1:0]    red;
  logic [pfrc_pkg::BYTE_W-1:0]    green;
  logic [pfrc_pkg::BYTE_W-1:0]    blue;
  logic [pfrc_pkg::BYTE_W-1:0]    alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

`default_nettype wire

// ===== rtl/pfrc_apb_regs.sv =====
// APB register block holding the pixel_format register.
// Depends on pfrc_pkg for widths and register codes.
`default_nettype none

module pfrc_apb_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pfrc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [pfrc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [pfrc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output logic      [pfrc_pkg::FMT_W-1:0]          pixel_format
);

  logic wr_en;
  logic reg_hit;

  assign pready = 1'b1;
  assign reg_hit = (paddr[2] == pfrc_pkg::REG_PIXEL_FORMAT);
  assign wr_en = psel && penable && pwrite && reg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= pfrc_pkg::FMT_RGB24;
    end else if (wr_en) begin
      pixel_format <= pwdata[pfrc_pkg::FMT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata[pfrc_pkg::FMT_W-1:0] = pixel_format;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfrc_convert.sv =====
// Combinational colour conversion of one pixel: packed swizzles, grey
// replication and BT.601 limited-range YUV to RGB. Depends on pfrc_pkg.
`default_nettype none

module pfrc_convert (
  input  wire logic [pfrc_pkg::FMT_W-1:0]   pixel_format,
  input  wire logic [pfrc_pkg::BYTE_W-1:0]  first_byte,
  input  wire logic [pfrc_pkg::BYTE_W-1:0]  second_byte,
  input  wire logic [pfrc_pkg::BYTE_W-1:0]  third_byte,
  output pfrc_pkg::rgb_t                    rgb,
  output logic                              supported
);

  logic [pfrc_pkg::BYTE_W-1:0]         u_byte;
  logic [pfrc_pkg::BYTE_W-1:0]         v_byte;
  logic signed [9:0]                   c;
  logic signed [9:0]                   d;
  logic signed [9:0]                   e;
  logic signed [pfrc_pkg::SUM_W-1:0]   y_term;
  logic signed [pfrc_pkg::SUM_W-1:0]   sum_r;
  logic signed [pfrc_pkg::SUM_W-1:0]   sum_g;
  logic signed [pfrc_pkg::SUM_W-1:0]   sum_b;
  pfrc_pkg::rgb_t                      yuv_rgb;

  // NV21 stores V before U
  assign u_byte = (pixel_format == pfrc_pkg::FMT_NV21) ? third_byte : second_byte;
  assign v_byte = (pixel_format == pfrc_pkg::FMT_NV21) ? second_byte : third_byte;

  assign c = $signed({2'b00, first_byte}) - pfrc_pkg::LUMA_OFS;
  assign d = $signed({2'b00, u_byte}) - pfrc_pkg::CHROMA_OFS;
  assign e = $signed({2'b00, v_byte}) - pfrc_pkg::CHROMA_OFS;

  assign y_term = pfrc_pkg::SUM_W'(c) * pfrc_pkg::K_Y + pfrc_pkg::ROUND;
  assign sum_r = y_term + pfrc_pkg::SUM_W'(e) * pfrc_pkg::K_RV;
  assign sum_g = y_term - pfrc_pkg::SUM_W'(d) * pfrc_pkg::K_GU
               - pfrc_pkg::SUM_W'(e) * pfrc_pkg::K_GV;
  assign sum_b = y_term + pfrc_pkg::SUM_W'(d) * pfrc_pkg::K_BU;

  assign yuv_rgb.red = pfrc_pkg::clamp_shift(sum_r);
  assign yuv_rgb.green = pfrc_pkg::clamp_shift(sum_g);
  assign yuv_rgb.blue = pfrc_pkg::clamp_shift(sum_b);

  always_comb begin
    supported = 1'b1;
    rgb = yuv_rgb;
    case (pixel_format)
      pfrc_pkg::FMT_RGB24: begin
        rgb.red = first_byte;
        rgb.green = second_byte;
        rgb.blue = third_byte;
      end
      pfrc_pkg::FMT_BGR24: begin
        rgb.red = third_byte;
        rgb.green = second_byte;
        rgb.blue = first_byte;
      end
      pfrc_pkg::FMT_GRAY8: begin
        rgb.red = first_byte;
        rgb.green = first_byte;
        rgb.blue = first_byte;
      end
      pfrc_pkg::FMT_NV12, pfrc_pkg::FMT_NV21, pfrc_pkg::FMT_I420: begin
        rgb = yuv_rgb;
      end
      default: begin
        supported = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pixel_format_to_rgba_converter.sv =====
// Top level of the pixel format to RGBA converter.
// Depends on pfrc_pkg, pfrc_if, pfrc_apb_regs and pfrc_convert.
//
// Usage:
//   pixel (sink): three source bytes per pixel, valid/ready; a transfer
//   happens on a clock edge with valid and ready both high.
//   rgba (source): one RGBA result per supported pixel, alpha always 255.
//   APB port: pixel_format at byte address 0; the user must see that it is
//   written only while idle, which the block itself does not enforce.
// An input transfer loads the input register; the conversion logic feeds the
//   result register, which drives the rgba outputs.
// Throughput: one pixel per cycle while the receiver does not stall, set by
//   the two register stages with a single multiply-add level between them.
// Pixels arriving while pixel_format holds 6 or 7 are taken and dropped.
// Reset (rst, synchronous) empties both stages and sets rgb24.
// When the receiver stalls, the result register holds and the input
//   register fills; ready then drops until a result transfer frees a slot.
`default_nettype none

module pixel_format_to_rgba_converter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  pfrc_pixel_if.sink                             pixel,
  pfrc_rgba_if.source                            rgba,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pfrc_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [pfrc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [pfrc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  logic [pfrc_pkg::FMT_W-1:0]   pixel_format;
  logic                         s1_valid;
  logic                         s1_ready;
  logic [pfrc_pkg::BYTE_W-1:0]  s1_first;
  logic [pfrc_pkg::BYTE_W-1:0]  s1_second;
  logic [pfrc_pkg::BYTE_W-1:0]  s1_third;
  pfrc_pkg::rgb_t               conv_rgb;
  logic                         conv_ok;
  logic                         out_valid;
  logic                         out_free;
  pfrc_pkg::rgb_t               out_rgb;

  pfrc_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_format (pixel_format)
  );

  pfrc_convert u_convert (
    .pixel_format (pixel_format),
    .first_byte   (s1_first),
    .second_byte  (s1_second),
    .third_byte   (s1_third),
    .rgb          (conv_rgb),
    .supported    (conv_ok)
  );

  assign out_free = !out_valid || rgba.ready;
  assign s1_ready = !s1_valid || !conv_ok || out_free;
  assign pixel.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && s1_ready) begin
      s1_first <= pixel.first_byte;
      s1_second <= pixel.second_byte;
      s1_third <= pixel.third_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && conv_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid && conv_ok) begin
      out_rgb <= conv_rgb;
    end
  end

  assign rgba.valid = out_valid;
  assign rgba.red = out_rgb.red;
  assign rgba.green = out_rgb.green;
  assign rgba.blue = out_rgb.blue;
  assign rgba.alpha = pfrc_pkg::ALPHA_OPAQUE;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for pixel_format_to_rgba_converter: directed and random pixels
// per format, APB register writes and reads, random source gaps and sink stalls.
// Depends on pfrc_pkg, pfrc_if and the converter RTL.
`default_nettype none

module tb_top;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 10;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_PIXELS = 1500;
  localparam int STREAM_PIXELS = 200;

  localparam logic [pfrc_pkg::FMT_W-1:0] FMT_RSVD6 = 3'd6;
  localparam logic [pfrc_pkg::FMT_W-1:0] FMT_RSVD7 = 3'd7;

  localparam logic [pfrc_pkg::APB_ADDR_W-1:0] ADDR_PIXEL_FORMAT = 3'd0;
  localparam logic [pfrc_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

  typedef struct {
    logic [pfrc_pkg::BYTE_W-1:0] red;
    logic [pfrc_pkg::BYTE_W-1:0] green;
    logic [pfrc_pkg::BYTE_W-1:0] blue;
    logic [pfrc_pkg::BYTE_W-1:0] alpha;
  } rgba_px_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [pfrc_pkg::APB_ADDR_W-1:0] paddr;
  logic [pfrc_pkg::APB_DATA_W-1:0] pwdata;
  logic [pfrc_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  pfrc_pixel_if pix_if ();
  pfrc_rgba_if rgba_if ();

  pixel_format_to_rgba_converter dut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pix_if),
    .rgba    (rgba_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rgba_px_t rgba_due_q[$];
  logic [pfrc_pkg::FMT_W-1:0] fmt_shadow;
  int err_count;
  bit src_gaps;
  bit sink_stalls;
  int holdoff_req;
  int holdoff_left;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * 600000);
    $display("** pixel_format_to_rgba_converter: FAILED **");
    $finish;
  end

  function automatic logic [pfrc_pkg::BYTE_W-1:0] saturate_channel(input int sum);
    int q;
    if (sum < 0) begin
      return '0;
    end
    q = sum >>> 8;
    if (q > 255) begin
      return 8'hFF;
    end
    return q[pfrc_pkg::BYTE_W-1:0];
  endfunction

  function automatic bit convert_pixel(input logic [pfrc_pkg::FMT_W-1:0] fmt,
                                       input logic [pfrc_pkg::BYTE_W-1:0] b0,
                                       input logic [pfrc_pkg::BYTE_W-1:0] b1,
                                       input logic [pfrc_pkg::BYTE_W-1:0] b2,
                                       output rgba_px_t px);
    int u;
    int v;
    int c;
    int d;
    int e;
    px.alpha = 8'hFF;
    case (fmt)
      pfrc_pkg::FMT_RGB24: begin
        px.red = b0;
        px.green = b1;
        px.blue = b2;
      end
      pfrc_pkg::FMT_BGR24: begin
        px.red = b2;
        px.green = b1;
        px.blue = b0;
      end
      pfrc_pkg::FMT_GRAY8: begin
        px.red = b0;
        px.green = b0;
        px.blue = b0;
      end
      pfrc_pkg::FMT_NV12, pfrc_pkg::FMT_NV21, pfrc_pkg::FMT_I420: begin
        // nv21 stores V before U
        u = (fmt == pfrc_pkg::FMT_NV21) ? int'(b2) : int'(b1);
        v = (fmt == pfrc_pkg::FMT_NV21) ? int'(b1) : int'(b2);
        c = int'(b0) - 16;
        d = u - 128;
        e = v - 128;
        px.red = saturate_channel(298 * c + 409 * e + 128);
        px.green = saturate_channel(298 * c - 100 * d - 208 * e + 128);
        px.blue = saturate_channel(298 * c + 516 * d + 128);
      end
      default: begin
        px.red = '0;
        px.green = '0;
        px.blue = '0;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // biased towards the corners of the luma and chroma ranges
  function automatic logic [pfrc_pkg::BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 11))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd16;
      3: return 8'd235;
      4: return 8'd128;
      5: return 8'd240;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    rgba_px_t want;
    if (!rst && rgba_if.valid && rgba_if.ready) begin
      if (rgba_due_q.size() == 0) begin
        report_mismatch("unexpected result transfer", 1, 0);
      end else begin
        want = rgba_due_q.pop_front();
        if (rgba_if.red !== want.red)
          report_mismatch("red", int'(rgba_if.red), int'(want.red));
        if (rgba_if.green !== want.green)
          report_mismatch("green", int'(rgba_if.green), int'(want.green));
        if (rgba_if.blue !== want.blue)
          report_mismatch("blue", int'(rgba_if.blue), int'(want.blue));
        if (rgba_if.alpha !== want.alpha)
          report_mismatch("alpha", int'(rgba_if.alpha), int'(want.alpha));
      end
    end
  end

  // sink ready: long hold-off, random stall bursts, or always ready
  always @(negedge clk) begin
    if (holdoff_req > 0) begin
      holdoff_left = holdoff_req;
      holdoff_req = 0;
    end
    if (holdoff_left > 0) begin
      rgba_if.ready = 1'b0;
      holdoff_left--;
    end else if (!sink_stalls) begin
      rgba_if.ready = 1'b1;
    end else if (stall_left > 0) begin
      rgba_if.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      rgba_if.ready = 1'b0;
      stall_left = $urandom_range(1, 8) - 1;
    end else begin
      rgba_if.ready = 1'b1;
    end
  end

  // called and returns just after a falling edge; valid stays high on return
  task automatic send_pixel(input logic [pfrc_pkg::BYTE_W-1:0] b0,
                            input logic [pfrc_pkg::BYTE_W-1:0] b1,
                            input logic [pfrc_pkg::BYTE_W-1:0] b2);
    int gap;
    rgba_px_t px;
    gap = 0;
    if (src_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      pix_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.valid = 1'b1;
    pix_if.first_byte = b0;
    pix_if.second_byte = b1;
    pix_if.third_byte = b2;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    if (convert_pixel(fmt_shadow, b0, b1, b2, px)) begin
      rgba_due_q.push_back(px);
    end
    @(negedge clk);
  endtask

  // source quiet, every result in, pipeline settled (dropped pixels leave no trace)
  task automatic wait_idle();
    pix_if.valid = 1'b0;
    while (rgba_due_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [pfrc_pkg::APB_ADDR_W-1:0] addr,
                           input logic [pfrc_pkg::APB_DATA_W-1:0] data);
    wait_idle();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[pfrc_pkg::APB_ADDR_W-1] == pfrc_pkg::REG_PIXEL_FORMAT)
      fmt_shadow = data[pfrc_pkg::FMT_W-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic read_back_format();
    logic [pfrc_pkg::APB_DATA_W-1:0] rd;
    wait_idle();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_PIXEL_FORMAT;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (rd[pfrc_pkg::FMT_W-1:0] !== fmt_shadow)
      report_mismatch("pixel_format readback", int'(rd), int'(fmt_shadow));
  endtask

  task automatic write_format(input logic [pfrc_pkg::FMT_W-1:0] fmt);
    logic [pfrc_pkg::APB_DATA_W-1:0] data;
    data = $urandom();
    data[pfrc_pkg::FMT_W-1:0] = fmt;
    apb_write(ADDR_PIXEL_FORMAT, data);
  endtask

  task automatic test_directed();
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    read_back_format();
    // reset format is rgb24
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'h5A, 8'hA5, 8'h3C);
    write_format(pfrc_pkg::FMT_BGR24);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd1, 8'd2, 8'd3);
    // gray8 ignores the second and third bytes
    write_format(pfrc_pkg::FMT_GRAY8);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd128, rand_byte(), rand_byte());
    // nv12: black, white, negative sums clamp to 0, overflow saturates
    write_format(pfrc_pkg::FMT_NV12);
    send_pixel(8'd16, 8'd128, 8'd128);
    send_pixel(8'd235, 8'd128, 8'd128);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    write_format(pfrc_pkg::FMT_NV21);
    send_pixel(8'd81, 8'd90, 8'd240);
    send_pixel(8'd255, 8'd0, 8'd255);
    write_format(pfrc_pkg::FMT_I420);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    // unsupported formats drop the pixel
    write_format(FMT_RSVD6);
    send_pixel(8'd100, 8'd100, 8'd100);
    send_pixel(8'd255, 8'd255, 8'd255);
    write_format(FMT_RSVD7);
    send_pixel(8'd0, 8'd0, 8'd0);
    // write to an unmapped register index leaves the format alone
    write_format(pfrc_pkg::FMT_RGB24);
    apb_write(ADDR_UNMAPPED, {29'd0, pfrc_pkg::FMT_GRAY8});
    read_back_format();
    send_pixel(8'd10, 8'd20, 8'd30);
  endtask

  task automatic test_register_access();
    for (int v = 0; v < 8; v++) begin
      write_format(pfrc_pkg::FMT_W'(v));
      read_back_format();
    end
    apb_write(ADDR_UNMAPPED, $urandom());
    read_back_format();
  endtask

  task automatic test_random_formats();
    int counted;
    int n;
    logic [pfrc_pkg::FMT_W-1:0] f;
    counted = 0;
    while (counted < RANDOM_PIXELS) begin
      if ($urandom_range(0, 9) == 0) f = pfrc_pkg::FMT_W'($urandom_range(6, 7));
      else f = pfrc_pkg::FMT_W'($urandom_range(0, 5));
      if ($urandom_range(0, 3) == 0) apb_write(ADDR_UNMAPPED, $urandom());
      write_format(f);
      src_gaps = ($urandom_range(0, 4) != 0);
      sink_stalls = ($urandom_range(0, 4) != 0);
      n = (f <= pfrc_pkg::FMT_I420) ? $urandom_range(20, 120) : $urandom_range(5, 15);
      repeat (n) send_pixel(rand_byte(), rand_byte(), rand_byte());
      if (f <= pfrc_pkg::FMT_I420) counted += n;
      if ($urandom_range(0, 3) == 0) read_back_format();
    end
  endtask

  // sink holds off while the source keeps offering, then source waits for a full drain
  task automatic test_backpressure();
    write_format(pfrc_pkg::FMT_NV12);
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    holdoff_req = 60;
    repeat (30) send_pixel(rand_byte(), rand_byte(), rand_byte());
    wait_idle();
    write_format(pfrc_pkg::FMT_BGR24);
    holdoff_req = 40;
    repeat (15) send_pixel(rand_byte(), rand_byte(), rand_byte());
    wait_idle();
    repeat (10) send_pixel(rand_byte(), rand_byte(), rand_byte());
  endtask

  task automatic test_streaming();
    write_format(pfrc_pkg::FMT_I420);
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (STREAM_PIXELS / 2) send_pixel(rand_byte(), rand_byte(), rand_byte());
    write_format(pfrc_pkg::FMT_NV21);
    repeat (STREAM_PIXELS / 2) send_pixel(rand_byte(), rand_byte(), rand_byte());
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_if.valid = 1'b0;
    pix_if.first_byte = '0;
    pix_if.second_byte = '0;
    pix_if.third_byte = '0;
    rgba_if.ready = 1'b0;
    fmt_shadow = pfrc_pkg::FMT_RGB24;
    err_count = 0;
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    holdoff_req = 0;
    holdoff_left = 0;
    stall_left = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_directed();
    test_register_access();
    test_random_formats();
    test_backpressure();
    test_streaming();

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_count == 0 && rgba_due_q.size() == 0) begin
      $display("** pixel_format_to_rgba_converter: PASSED **");
    end else begin
      $display("** pixel_format_to_rgba_converter: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/pfrc_pkg.sv
rtl/pfrc_if.sv
rtl/pfrc_apb_regs.sv
rtl/pfrc_convert.sv
rtl/pixel_format_to_rgba_converter.sv
tb/sv/tb_top.sv
